// ===== hdl/upe_pkg.sv =====
// Shared types, codes and character helpers for the URL percent encoder.
`default_nettype none

package upe_pkg;

  localparam int unsigned CAP_W  = 16;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_DASH    = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

  // configuration register indexes
  localparam logic CFG_SPACE_AS_PLUS = 1'b0;
  localparam logic CFG_OUT_CAPACITY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef struct packed {
    status_t           status;
    logic              last;
    logic              has;
    logic [BYTE_W-1:0] chr;
  } res_t;

  typedef struct packed {
    res_t       r2;
    res_t       r1;
    res_t       r0;
    logic [1:0] last_idx;
    logic [1:0] cnt_add;
    logic       set_err;
  } upe_dec_t;

  function automatic res_t mk_res(logic [BYTE_W-1:0] chr, logic has, logic last,
                                  status_t status);
    res_t r;
    r.chr    = chr;
    r.has    = has;
    r.last   = last;
    r.status = status;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] nib);
    logic [BYTE_W-1:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
    else             c = 8'h37 + {4'd0, nib};
    return c;
  endfunction

  function automatic logic passes(logic [BYTE_W-1:0] c);
    logic p;
    p = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
        ((c >= 8'h30) && (c <= 8'h39)) ||
        (c == CH_DOT) || (c == CH_STAR) || (c == CH_UNDER) || (c == CH_DASH) ||
        (c == CH_PERCENT) || (c == CH_PLUS);
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/upe_encode.sv =====
// Per-byte encode decision: result characters, count step and overflow flag.
`default_nettype none

module upe_encode #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic [7:0]             in_byte,
  input  wire logic [COUNT_WIDTH-1:0] cnt,
  input  wire logic [15:0]            capacity,
  input  wire logic                   err,
  input  wire logic                   space_as_plus,
  output upe_pkg::upe_dec_t           dec
);
  import upe_pkg::*;

  localparam int unsigned CMP_W = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 2;

  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] cap_ext;
  logic             full;
  logic             fits;

  assign cnt_ext = CMP_W'(cnt);
  assign cap_ext = CMP_W'(capacity);
  assign full    = cnt_ext >= cap_ext;
  assign fits    = (cnt_ext + CMP_W'(3)) < cap_ext;

  always_comb begin
    dec          = '0;
    dec.r1       = mk_res(8'd0, 1'b0, 1'b0, ST_OK);
    dec.r2       = mk_res(8'd0, 1'b0, 1'b0, ST_OK);
    dec.last_idx = 2'd0;
    dec.cnt_add  = 2'd0;
    dec.set_err  = 1'b0;
    priority if (err) begin
      dec.r0 = mk_res(8'd0, 1'b0, 1'b1, ST_OVF);
    end else if (full) begin
      dec.r0 = mk_res(8'd0, 1'b0, 1'b1, ST_DROP);
    end else if (passes(in_byte)) begin
      dec.r0      = mk_res(in_byte, 1'b1, 1'b1, ST_OK);
      dec.cnt_add = 2'd1;
    end else if ((in_byte == CH_SPACE) && space_as_plus) begin
      dec.r0      = mk_res(CH_PLUS, 1'b1, 1'b1, ST_OK);
      dec.cnt_add = 2'd1;
    end else if (fits) begin
      dec.r0       = mk_res(CH_PERCENT, 1'b1, 1'b0, ST_OK);
      dec.r1       = mk_res(hex_char(in_byte[7:4]), 1'b1, 1'b0, ST_OK);
      dec.r2       = mk_res(hex_char(in_byte[3:0]), 1'b1, 1'b1, ST_OK);
      dec.last_idx = 2'd2;
      dec.cnt_add  = 2'd3;
    end else begin
      dec.r0      = mk_res(8'd0, 1'b0, 1'b1, ST_OVF);
      dec.set_err = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/url_percent_encoder_core.sv =====
// Streaming URL percent encoder top level: input stage, result sequencer, budget state.
// The input stage registers the byte; the result sequencer registers its results.
// Throughput: one input beat per cycle (pass-through, plus, dropped, overflow bytes)
// with out_tready high; an escaped byte stalls input until its three beats are taken.
// Reset (rst_n low, synchronous): pipeline empty, count and error cleared,
// space_as_plus = 1, out_capacity = 256.
`default_nettype none

module url_percent_encoder_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic [2:0]       out_tuser,  // [0] has_byte, [2:1] status
  output logic             out_tlast   // run_last
);
  import upe_pkg::*;

  logic                   space_r;
  logic [15:0]            cap_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic                   err_r;
  logic                   err_nxt;

  logic                   a_valid_r;
  logic [7:0]             a_byte_r;
  logic                   a_last_r;

  logic                   b_valid_r;
  res_t                   b_res_r [3];
  logic [1:0]             b_idx_r;
  logic [1:0]             b_last_r;

  upe_dec_t               dec;
  res_t                   cur;
  logic                   b_done;
  logic                   load;
  logic                   a_move;

  upe_encode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_enc (
    .in_byte       (a_byte_r),
    .cnt           (cnt_r),
    .capacity      (cap_r),
    .err           (err_r),
    .space_as_plus (space_r),
    .dec           (dec)
  );

  assign b_done    = b_valid_r && out_tready && (b_idx_r == b_last_r);
  assign load      = !b_valid_r || b_done;
  assign a_move    = a_valid_r && load;
  assign in_tready = !a_valid_r || load;

  assign cur        = b_res_r[b_idx_r];
  assign out_tvalid = b_valid_r;
  assign out_tdata  = cur.chr;
  assign out_tuser  = {cur.status, cur.has};
  assign out_tlast  = cur.last;

  assign cnt_nxt = a_last_r ? '0 : cnt_r + COUNT_WIDTH'(dec.cnt_add);
  assign err_nxt = a_last_r ? 1'b0 : (err_r | dec.set_err);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_r   <= 1'b1;
      cap_r     <= 16'd256;
      cnt_r     <= '0;
      err_r     <= 1'b0;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      b_idx_r   <= 2'd0;
      b_last_r  <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_SPACE_AS_PLUS: space_r <= cfg_wdata[0];
          CFG_OUT_CAPACITY:  cap_r   <= cfg_wdata;
          default:           ;
        endcase
      end
      if (in_tready) begin
        a_valid_r <= in_tvalid;
      end
      if (a_move) begin
        cnt_r <= cnt_nxt;
        err_r <= err_nxt;
      end
      if (load) begin
        b_valid_r <= a_valid_r;
        b_idx_r   <= 2'd0;
        b_last_r  <= dec.last_idx;
      end else if (b_valid_r && out_tready) begin
        b_idx_r <= b_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      a_byte_r <= in_tdata;
      a_last_r <= in_tlast;
    end
    if (a_move) begin
      b_res_r[0] <= dec.r0;
      b_res_r[1] <= dec.r1;
      b_res_r[2] <= dec.r2;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_idx_r <= b_last_r))
    else $error("result index past last entry");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (a_move && err_r) |-> ((dec.r0.status == ST_OVF) && (dec.last_idx == 2'd0)))
    else $error("sticky error did not yield a single overflow result");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("empty result beat not marked last");

  a_string_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (a_move && a_last_r) |=> ((cnt_r == '0) && !err_r))
    else $error("budget not cleared after last byte");
`endif

endmodule

`default_nettype wire
